@@ design/triangle_tangent_from_uv_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent unit
// Shared wrappers around concurrent assertions on clk, with and without reset
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FROM_UV_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_FROM_UV_UNIT_MACROS_SVH

// checked only outside reset
`define TTUV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TTUV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ttuv_pkg.sv @@
// ----------------------------------------------------------------------------
// ttuv_pkg
// Widths, triangle record and sequencer states shared by the tangent unit
// ----------------------------------------------------------------------------
package ttuv_pkg;

  localparam int FIELD_W = 32;   // input coordinate field
  localparam int DIFF_W  = 33;   // edge / uv difference
  localparam int OPA_W   = 34;   // multiplicand, room for negation
  localparam int CHUNK_W = 11;   // multiplier digit
  localparam int PROD_W  = OPA_W + CHUNK_W + 1;
  localparam int ACC_W   = 69;   // products summed, flip-safe
  localparam int MAG_W   = 68;   // tangent magnitude
  localparam int NORM_W  = 30;   // normalised magnitude bits
  localparam int SUM_W   = 62;   // sum of squares
  localparam int RT_W    = 64;   // square root working width
  localparam int LEN_W   = 31;   // root
  localparam int NUM_W   = 48;   // division numerator
  localparam int QUO_W   = 18;   // quotient bits
  localparam int REM_W   = 31;
  localparam int TAN_W   = 18;   // Q1.16 output
  localparam int QDEPTH  = 2;
  localparam int PTR_W   = 1;
  localparam int CNT_W   = 2;
  localparam logic [QUO_W-1:0] UNITY = QUO_W'(65536);

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    diff_t                    du10;
    diff_t                    dt10;
    diff_t                    du20;
    diff_t                    dt20;
    logic [2:0][DIFF_W-1:0]   e10;
    logic [2:0][DIFF_W-1:0]   e20;
  } tri_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_MAG, B_NORM, B_SQ, B_SQRT, B_DIV, B_EMIT
  } bstate_t;

endpackage

@@ design/ttuv_front.sv @@
// ----------------------------------------------------------------------------
// ttuv_front
// Holds the first two corners and turns the third into a difference record
// ----------------------------------------------------------------------------
module ttuv_front import ttuv_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic signed [FIELD_W-1:0] pos_z,
  input  logic signed [FIELD_W-1:0] tex_u,
  input  logic signed [FIELD_W-1:0] tex_v,
  input  logic                      end_of_mesh,
  output logic                      push,
  output tri_t                      push_data,
  input  logic                      q_full
);

  localparam int CW = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int SH = FIELD_W - CW;

  logic signed [FIELD_W-1:0] c [5];
  logic signed [FIELD_W-1:0] slot0 [5];
  logic signed [FIELD_W-1:0] slot1 [5];
  logic [1:0] corner_count;
  logic       accept;

  // keep the low CW bits, sign-extended
  assign c[0] = $signed(pos_x << SH) >>> SH;
  assign c[1] = $signed(pos_y << SH) >>> SH;
  assign c[2] = $signed(pos_z << SH) >>> SH;
  assign c[3] = $signed(tex_u << SH) >>> SH;
  assign c[4] = $signed(tex_v << SH) >>> SH;

  assign in_stall = (corner_count == 2'd2) && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (corner_count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      if (corner_count == 2'd2 || end_of_mesh) corner_count <= 2'd0;
      else corner_count <= corner_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && corner_count == 2'd0) slot0 <= c;
    if (accept && corner_count == 2'd1) slot1 <= c;
  end

  function automatic diff_t dif(input logic signed [FIELD_W-1:0] a,
                                input logic signed [FIELD_W-1:0] b);
    dif = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  always_comb begin
    push_data.du10 = dif(slot1[3], slot0[3]);
    push_data.dt10 = dif(slot1[4], slot0[4]);
    push_data.du20 = dif(c[3], slot0[3]);
    push_data.dt20 = dif(c[4], slot0[4]);
    for (int i = 0; i < 3; i++) begin
      push_data.e10[i] = dif(slot1[i], slot0[i]);
      push_data.e20[i] = dif(c[i], slot0[i]);
    end
  end

endmodule

@@ design/ttuv_queue.sv @@
// ----------------------------------------------------------------------------
// ttuv_queue
// Short queue of triangle records between front and back
// ----------------------------------------------------------------------------
`include "triangle_tangent_from_uv_unit_macros.svh"

module ttuv_queue import ttuv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tri_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output tri_t head_data
);

  tri_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt == CNT_W'(QDEPTH));
  assign head_valid = (cnt != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      cnt <= cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  `TTUV_ASSERT(a_cnt_bound, cnt <= CNT_W'(QDEPTH), "queue over depth")
  `TTUV_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
  `TTUV_ASSERT(a_fill, (do_push && !do_pop) |=> cnt == $past(cnt) + 1'b1, "fill count slip")

endmodule

@@ design/ttuv_back.sv @@
// ----------------------------------------------------------------------------
// ttuv_back
// Tangent sequencer: cross products, flip, normalise, squares, root, divide, emit
// ----------------------------------------------------------------------------
`include "triangle_tangent_from_uv_unit_macros.svh"

module ttuv_back import ttuv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  tri_t                    head_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TAN_W-1:0] tangent_x,
  output logic signed [TAN_W-1:0] tangent_y,
  output logic signed [TAN_W-1:0] tangent_z,
  output logic                    degenerate,
  output logic                    last_of_triangle
);

  bstate_t state, state_next;

  tri_t                     op;
  logic [1:0]               term;
  logic                     half;
  logic [1:0]               chunk;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  t [3];
  logic                     det_neg;
  logic [MAG_W-1:0]         m [3];
  logic                     neg [3];
  logic                     degen;
  logic [SUM_W-1:0]         sum;
  logic [RT_W-1:0]          x;
  logic [RT_W-1:0]          res;
  logic [RT_W-1:0]          bitv;
  logic [4:0]               iter;
  logic [LEN_W-1:0]         len;
  logic [1:0]               comp;
  logic [4:0]               dstep;
  logic [REM_W-1:0]         rem;
  logic [QUO_W-1:0]         divn;
  logic [QUO_W-1:0]         quo;
  logic signed [TAN_W-1:0]  r [3];
  logic [1:0]               emit_cnt;

  // multiply step
  diff_t                    a_sel;
  diff_t                    b_sel;
  logic signed [OPA_W-1:0]  a34;
  logic signed [CHUNK_W:0]  dig;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  pp;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     mul_last;

  // other steps
  logic [MAG_W-1:0]         mor;
  logic                     norm_done;
  logic                     degen_c;
  logic [RT_W-1:0]          trial_rt;
  logic [NUM_W-1:0]         num;
  logic [REM_W:0]           trial_dv;
  logic [QUO_W-1:0]         quo_next;
  logic [QUO_W-1:0]         qsat;
  logic                     out_take;

  always_comb begin
    a_sel = half ? op.du10 : op.du20;
    if (term != 2'd0) a_sel = half ? op.e10[term - 2'd1] : op.e20[term - 2'd1];
    b_sel = half ? op.dt20 : op.dt10;
    a34   = half ? -OPA_W'(a_sel) : OPA_W'(a_sel);
    case (chunk)
      2'd0:    dig = $signed({1'b0, b_sel[CHUNK_W-1:0]});
      2'd1:    dig = $signed({1'b0, b_sel[2*CHUNK_W-1:CHUNK_W]});
      default: dig = $signed({b_sel[DIFF_W-1], b_sel[DIFF_W-1:2*CHUNK_W]});
    endcase
    prod = a34 * dig;
    case (chunk)
      2'd0:    pp = ACC_W'(prod);
      2'd1:    pp = ACC_W'(prod) <<< CHUNK_W;
      default: pp = ACC_W'(prod) <<< (2 * CHUNK_W);
    endcase
    acc_next = acc + pp;
    mul_last = (chunk == 2'd2) && half;
  end

  assign degen_c   = (t[0] == '0) && (t[1] == '0) && (t[2] == '0);
  assign mor       = m[0] | m[1] | m[2];
  assign norm_done = (mor[MAG_W-1:NORM_W] == '0) && mor[NORM_W-1];
  assign trial_rt  = res + bitv;
  assign num       = NUM_W'({m[comp][NORM_W-1:0], 16'b0}) + NUM_W'(len >> 1);
  assign trial_dv  = {rem, divn[QUO_W-1]};

  always_comb begin
    quo_next = {quo[QUO_W-2:0], (trial_dv >= (REM_W + 1)'(len))};
    qsat     = (quo_next > UNITY) ? UNITY : quo_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (head_valid) state_next = B_MUL;
      B_MUL:  if (mul_last && term == 2'd3) state_next = B_MAG;
      B_MAG:  state_next = degen_c ? B_EMIT : B_NORM;
      B_NORM: if (norm_done) state_next = B_SQ;
      B_SQ:   if (comp == 2'd2) state_next = B_SQRT;
      B_SQRT: if (iter == 5'd31) state_next = B_DIV;
      B_DIV:  if (dstep == 5'd18 && comp == 2'd2) state_next = B_EMIT;
      B_EMIT: if (!out_stall && emit_cnt == 2'd2) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      B_IDLE:  pop = head_valid;
      B_EMIT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_take         = out_valid && !out_stall;
  assign tangent_x        = r[0];
  assign tangent_y        = r[1];
  assign tangent_z        = r[2];
  assign degenerate       = degen;
  assign last_of_triangle = (emit_cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      emit_cnt <= 2'd0;
    end else begin
      state <= state_next;
      if (out_take) emit_cnt <= (emit_cnt == 2'd2) ? 2'd0 : emit_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        op    <= head_data;
        term  <= 2'd0;
        half  <= 1'b0;
        chunk <= 2'd0;
        acc   <= '0;
      end
      B_MUL: begin
        if (chunk == 2'd2) begin
          chunk <= 2'd0;
          half  <= ~half;
        end else begin
          chunk <= chunk + 2'd1;
        end
        if (mul_last) begin
          acc  <= '0;
          term <= term + 2'd1;
          if (term == 2'd0) det_neg <= acc_next[ACC_W-1];
          else t[term - 2'd1] <= acc_next;
        end else begin
          acc <= acc_next;
        end
      end
      B_MAG: begin
        degen <= degen_c;
        for (int i = 0; i < 3; i++) begin
          neg[i] <= det_neg ? (t[i] > 0) : (t[i] < 0);
          m[i]   <= MAG_W'(t[i] < 0 ? -t[i] : t[i]);
          r[i]   <= '0;
        end
        comp <= 2'd0;
        sum  <= '0;
      end
      B_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mor[MAG_W-1:NORM_W+8] != '0)    m[i] <= m[i] >> 8;
          else if (mor[MAG_W-1:NORM_W] != '0) m[i] <= m[i] >> 1;
          else if (mor[NORM_W-1:21] == '0)    m[i] <= m[i] << 8;
          else if (!mor[NORM_W-1])            m[i] <= m[i] << 1;
        end
      end
      B_SQ: begin
        sum  <= sum + SUM_W'(m[comp][NORM_W-1:0] * m[comp][NORM_W-1:0]);
        comp <= comp + 2'd1;
        x    <= RT_W'(sum + SUM_W'(m[comp][NORM_W-1:0] * m[comp][NORM_W-1:0]));
        res  <= '0;
        bitv <= RT_W'(1) << 62;
        iter <= 5'd0;
      end
      B_SQRT: begin
        if (x >= trial_rt) begin
          x   <= x - trial_rt;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv  <= bitv >> 2;
        iter  <= iter + 5'd1;
        len   <= (x >= trial_rt) ? LEN_W'((res >> 1) + bitv) : LEN_W'(res >> 1);
        comp  <= 2'd0;
        dstep <= 5'd0;
      end
      B_DIV: begin
        if (dstep == 5'd0) begin
          rem   <= REM_W'(num[NUM_W-1:QUO_W]);
          divn  <= num[QUO_W-1:0];
          quo   <= '0;
          dstep <= 5'd1;
        end else begin
          rem   <= (trial_dv >= (REM_W + 1)'(len)) ?
                   REM_W'(trial_dv - (REM_W + 1)'(len)) : REM_W'(trial_dv);
          divn  <= divn << 1;
          quo   <= quo_next;
          if (dstep == 5'd18) begin
            r[comp] <= neg[comp] ? -$signed(TAN_W'(qsat)) : $signed(TAN_W'(qsat));
            comp    <= comp + 2'd1;
            dstep   <= 5'd0;
          end else begin
            dstep <= dstep + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  `TTUV_ASSERT(a_last_ends, (out_take && last_of_triangle) |=> !out_valid,
    "result after last word of triangle")
  `TTUV_ASSERT(a_degen_zero, (out_valid && degenerate) |->
    (tangent_x == '0 && tangent_y == '0 && tangent_z == '0), "degenerate not zero")
  `TTUV_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid &&
    $stable(emit_cnt) && $stable(tangent_x)), "stalled word changed")

endmodule

@@ design/triangle_tangent_from_uv_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_unit
// Per-triangle unit tangent from position and uv gradients, three words out
// ----------------------------------------------------------------------------
// Input channel: one vertex word per accepted cycle (in_valid high, in_stall
// low), Q16.16 position and uv plus end_of_mesh. Vertices are taken one per
// cycle; in_stall rises only when a third corner meets a full triangle queue.
// Output channel: three words per complete triangle, tangent in Q1.16, the
// third flagged by last_of_triangle; degenerate marks a zero-length tangent.
// The back end handles one triangle at a time: 34x12 multiply steps, a flip
// step, normalising shifts, 3 squares, 32 root steps and 3 x 19 divide
// steps, then the three words; a degenerate triangle skips straight to
// output after the flip step. The root and the divider are bit-serial.
// A two-deep queue sits between corner capture and the sequencer.
// Reset (rst, synchronous) empties the queue, clears the corner count and
// idles the sequencer; held corners are simply overwritten.
// A stalled output word holds its value; the sequencer waits meanwhile.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv_unit import ttuv_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic signed [FIELD_W-1:0] pos_z,
  input  logic signed [FIELD_W-1:0] tex_u,
  input  logic signed [FIELD_W-1:0] tex_v,
  input  logic                      end_of_mesh,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TAN_W-1:0]   tangent_x,
  output logic signed [TAN_W-1:0]   tangent_y,
  output logic signed [TAN_W-1:0]   tangent_z,
  output logic                      degenerate,
  output logic                      last_of_triangle
);

  logic push;
  tri_t push_data;
  logic q_full;
  logic pop;
  logic head_valid;
  tri_t head_data;

  // corner capture and edge differences
  ttuv_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v, .end_of_mesh,
    .push, .push_data, .q_full
  );

  // decoupling queue
  ttuv_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full),
    .pop, .head_valid, .head_data
  );

  // tangent sequencer with output register
  ttuv_back u_back (
    .clk, .rst, .head_valid, .head_data, .pop,
    .out_valid, .out_stall, .tangent_x, .tangent_y, .tangent_z,
    .degenerate, .last_of_triangle
  );

endmodule
